@@ src/lpr_pkg.sv @@
package lpr_pkg;

  localparam int MAX_FRAMES_DEF = 512;
  localparam int PAGE_BITS_DEF = 20;
  localparam int CFG_W = 10;
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(64);
  localparam int CNT_BITS = 32;

  // Control that travels with a reference down the cell chain
  typedef struct packed {
    logic valid;
    logic done;
    logic hit;
    logic evict;
  } wave_ctl_t;

endpackage

@@ src/lpr_cell.sv @@
module lpr_cell
  import lpr_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int PAGE_W = PAGE_BITS_DEF,
  parameter int CNT_W = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [CNT_W-1:0]  frames_eff,
  input  logic              nbr_occ,
  output logic              occ_after,
  input  wave_ctl_t         ctl_in,
  input  logic [PAGE_W-1:0] key_in,
  input  logic [PAGE_W-1:0] carry_in,
  output wave_ctl_t         ctl_out,
  output logic [PAGE_W-1:0] key_out,
  output logic [PAGE_W-1:0] carry_out
);

  localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX + 1);

  logic [PAGE_W-1:0] page;
  logic              occ;
  logic              active;
  logic              match;
  logic              fill;
  logic              evict;
  logic              pass;
  logic              full;

  assign active = ctl_in.valid && !ctl_in.done;
  assign full   = POS >= frames_eff;
  assign match  = active && occ && (page == key_in);
  assign fill   = active && !occ;
  // Last resident entry of a full store: drop it
  assign evict  = active && occ && !match && !nbr_occ && full;
  assign pass   = active && occ && !match && !evict;

  // Occupancy as seen by the reference one cell behind
  assign occ_after = occ || fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      ctl_out <= '0;
    end else if (advance) begin
      occ <= occ_after;
      ctl_out.valid <= ctl_in.valid;
      ctl_out.done  <= ctl_in.done || match || fill || evict;
      ctl_out.hit   <= ctl_in.hit || match;
      ctl_out.evict <= ctl_in.evict || evict;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // Every searching reference pushes its carry into this entry
      if (active) begin
        page <= carry_in;
      end
      key_out <= key_in;
      if (pass || evict) begin
        carry_out <= page;
      end else if (active) begin
        carry_out <= '0;
      end else begin
        carry_out <= carry_in;
      end
    end
  end

endmodule

@@ src/lpr_result.sv @@
module lpr_result
  import lpr_pkg::*;
#(
  parameter int PAGE_W = PAGE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  wave_ctl_t           ctl_in,
  input  logic [PAGE_W-1:0]   carry_in,
  input  logic                out_ready,
  output logic                advance,
  output logic                out_valid,
  output logic                hit,
  output logic                evicted_valid,
  output logic [PAGE_W-1:0]   evicted_page,
  output logic [CNT_BITS-1:0] total_hits,
  output logic [CNT_BITS-1:0] total_misses
);

  logic                load;
  logic [CNT_BITS-1:0] hit_counter;
  logic [CNT_BITS-1:0] miss_counter;
  logic [CNT_BITS-1:0] hit_counter_next;
  logic [CNT_BITS-1:0] miss_counter_next;

  // Freeze the chain only when a finished transaction has nowhere to go
  assign advance = !(ctl_in.valid && out_valid && !out_ready);
  assign load    = ctl_in.valid && advance;

  always_comb begin
    hit_counter_next  = hit_counter;
    miss_counter_next = miss_counter;
    if (ctl_in.hit) begin
      if (hit_counter != '1) begin
        hit_counter_next = hit_counter + CNT_BITS'(1);
      end
    end else begin
      if (miss_counter != '1) begin
        miss_counter_next = miss_counter + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      hit_counter  <= '0;
      miss_counter <= '0;
    end else if (load) begin
      out_valid    <= 1'b1;
      hit_counter  <= hit_counter_next;
      miss_counter <= miss_counter_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit           <= ctl_in.hit;
      evicted_valid <= ctl_in.evict;
      evicted_page  <= carry_in;
    end
  end

  assign total_hits   = hit_counter;
  assign total_misses = miss_counter;

endmodule

@@ src/lru_page_replacement_top.sv @@
// Channel   Handshake                 Payload
// in        in_valid / in_ready       page_number
// out       out_valid / out_ready     hit, evicted_valid, evicted_page,
//                                     total_hits, total_misses
// cfg       cfg_write_en              cfg_write_data (frames_in_use)
//
// One transaction per cycle sustained while the row is not frozen; a reference
// walks the MAX_FRAMES recency cells one per cycle, then the result register.
// Each cell holds one stack entry, most recent first, and its occupancy bit.
// Reset (rst, synchronous) empties the store, clears both counters and sets
// frames_in_use to 64.
// The whole row freezes only while a result waits at the output and the last
// cell also holds a finished transaction.
module lru_page_replacement_top
  import lpr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_W-1:0]     cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAGE_BITS-1:0] page_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [CNT_BITS-1:0]  total_hits,
  output logic [CNT_BITS-1:0]  total_misses
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int EW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]     frames_in_use;
  logic [EW-1:0]        frames_ext;
  logic [EW-1:0]        frames_clip;
  logic [CNT_W-1:0]     frames_eff;
  logic                 advance;

  wave_ctl_t            ctl_chain   [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0] key_chain   [MAX_FRAMES];
  logic [PAGE_BITS-1:0] carry_chain [MAX_FRAMES+1];
  logic                 occ_chain   [MAX_FRAMES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_write_en) begin
      frames_in_use <= cfg_write_data;
    end
  end

  // Zero frames acts as one, anything past the built depth as the depth
  assign frames_ext = EW'(frames_in_use);
  always_comb begin
    priority if (frames_ext == '0) begin
      frames_clip = EW'(1);
    end else if (frames_ext > EW'(MAX_FRAMES)) begin
      frames_clip = EW'(MAX_FRAMES);
    end else begin
      frames_clip = frames_ext;
    end
  end
  assign frames_eff = frames_clip[CNT_W-1:0];

  assign in_ready = advance;

  assign ctl_chain[0] = '{valid: in_valid && in_ready, done: 1'b0, hit: 1'b0, evict: 1'b0};
  assign key_chain[0]   = page_number;
  assign carry_chain[0] = page_number;
  assign occ_chain[MAX_FRAMES] = 1'b0;

  for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
    if (k == MAX_FRAMES - 1) begin : g_last
      lpr_cell #(
        .INDEX  (k),
        .PAGE_W (PAGE_BITS),
        .CNT_W  (CNT_W)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .advance    (advance),
        .frames_eff (frames_eff),
        .nbr_occ    (occ_chain[k+1]),
        .occ_after  (occ_chain[k]),
        .ctl_in     (ctl_chain[k]),
        .key_in     (key_chain[k]),
        .carry_in   (carry_chain[k]),
        .ctl_out    (ctl_chain[k+1]),
        .key_out    (),
        .carry_out  (carry_chain[k+1])
      );
    end else begin : g_mid
      lpr_cell #(
        .INDEX  (k),
        .PAGE_W (PAGE_BITS),
        .CNT_W  (CNT_W)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .advance    (advance),
        .frames_eff (frames_eff),
        .nbr_occ    (occ_chain[k+1]),
        .occ_after  (occ_chain[k]),
        .ctl_in     (ctl_chain[k]),
        .key_in     (key_chain[k]),
        .carry_in   (carry_chain[k]),
        .ctl_out    (ctl_chain[k+1]),
        .key_out    (key_chain[k+1]),
        .carry_out  (carry_chain[k+1])
      );
    end
  end

  lpr_result #(
    .PAGE_W (PAGE_BITS)
  ) u_result (
    .clk           (clk),
    .rst           (rst),
    .ctl_in        (ctl_chain[MAX_FRAMES]),
    .carry_in      (carry_chain[MAX_FRAMES]),
    .out_ready     (out_ready),
    .advance       (advance),
    .out_valid     (out_valid),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .total_hits    (total_hits),
    .total_misses  (total_misses)
  );

endmodule

@@ src/lpr_checker.sv @@
module lpr_checker
  import lpr_pkg::*;
#(
  parameter int PAGE_W = PAGE_BITS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic                hit,
  input logic                evicted_valid,
  input logic [PAGE_W-1:0]   evicted_page,
  input logic [CNT_BITS-1:0] total_hits,
  input logic [CNT_BITS-1:0] total_misses
);

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("hit reported together with an eviction");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted_valid) |-> (evicted_page == '0))
    else $error("evicted page nonzero without an eviction");

  // Consecutive transactions: counters never go backward
  a_counts_grow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) ##1 out_valid |->
      (total_hits >= $past(total_hits)) && (total_misses >= $past(total_misses)))
    else $error("running counts decreased");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(evicted_page) && $stable(total_hits)))
    else $error("stalled result changed");

endmodule

bind lru_page_replacement_top lpr_checker #(
  .PAGE_W (PAGE_BITS)
) u_lpr_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .hit           (hit),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .total_hits    (total_hits),
  .total_misses  (total_misses)
);
